// ===== design/tkfr_pkg.sv =====
// Shared constants, types and state encoding for the top-K frequency ranker.
`timescale 1ns / 1ps

package tkfr_pkg;

    // Identifier space and count width
    localparam int ID_SPACE     = 1024;
    localparam int ID_W         = $clog2(ID_SPACE);
    localparam int CNT_W        = 16;

    // Ranked list depth and rank counter width (counter also holds MAX_TOP)
    localparam int MAX_TOP      = 10;
    localparam int RNK_W        = $clog2(MAX_TOP + 1);

    // Field widths fixed by the interface
    localparam int TOPK_W       = 4;
    localparam int RANK_W       = 4;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = ID_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ID_W + ID_W + RANK_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // APB register map
    localparam int APB_AW       = 2;
    localparam int APB_DW       = 32;
    localparam logic [APB_AW-1:0] CFG_ADDR_TOP_COUNT = 2'd0;
    localparam logic [TOPK_W-1:0] TOP_COUNT_RESET    = 4'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EMIT,
        S_UPDATE,
        S_INSERT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic emit;
        logic update;
        logic insert;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic emit_more;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

// ===== design/tkfr_ctrl.sv =====
// Controller state machine of the top-K frequency ranker.
`timescale 1ns / 1ps

module tkfr_ctrl import tkfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.emit_more) begin
                    n_state = S_UPDATE;
                end else if (i_sts.out_free && i_sts.emit_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_INSERT;
            end
            S_INSERT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.emit_more && i_sts.out_free;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/tkfr_dp.sv =====
// Datapath of the top-K frequency ranker: count memory, ranked list, output register.
`timescale 1ns / 1ps

module tkfr_dp import tkfr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [ID_W-1:0]        i_item_id,
    input  logic [TOPK_W-1:0]      i_top_count,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    // Count memory and its read register
    logic [CNT_W-1:0]       r_cnt_mem [ID_SPACE];
    logic [CNT_W-1:0]       r_rd;
    logic [ID_W-1:0]        r_clr_addr;

    // Item context
    logic [ID_W-1:0]        r_id;
    logic [RNK_W-1:0]       r_k;
    logic [RNK_W-1:0]       n_k;
    logic [RNK_W-1:0]       r_rank;
    logic [RNK_W-1:0]       rank_nx;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;

    // Ranked list
    logic [ID_W-1:0]        r_ids  [MAX_TOP];
    logic [CNT_W-1:0]       r_cnts [MAX_TOP];
    logic [MAX_TOP-1:0]     r_valid;
    logic [MAX_TOP:0]       valid_ext;
    logic [ID_W-1:0]        sel_id;

    // Removal and insertion results
    logic [ID_W-1:0]        rm_ids  [MAX_TOP];
    logic [CNT_W-1:0]       rm_cnts [MAX_TOP];
    logic [MAX_TOP-1:0]     rm_valid;
    logic [ID_W-1:0]        in_ids  [MAX_TOP];
    logic [CNT_W-1:0]       in_cnts [MAX_TOP];
    logic [MAX_TOP-1:0]     in_valid;

    // Output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;
    logic [OUT_TDATA_W-1:0] n_out_data;

    // Clamp the reported depth to 1..MAX_TOP
    always_comb begin
        if (i_top_count == '0) begin
            n_k = RNK_W'(1);
        end else if (32'(i_top_count) > MAX_TOP) begin
            n_k = RNK_W'(MAX_TOP);
        end else begin
            n_k = RNK_W'(i_top_count);
        end
    end

    // Saturating increment of the stored count
    assign n_cnt = (&r_rd) ? r_rd : r_rd + 1'b1;

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Count memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_cnt_mem[r_clr_addr] <= '0;
        end else if (i_cmd.update) begin
            r_cnt_mem[r_id] <= n_cnt;
        end
        if (i_cmd.accept) begin
            r_rd <= r_cnt_mem[i_item_id];
        end
    end

    // Latch item context, step the rank, hold the new count
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_id   <= i_item_id;
            r_k    <= n_k;
            r_rank <= '0;
        end else if (i_cmd.emit) begin
            r_rank <= rank_nx;
        end
        if (i_cmd.update) begin
            r_cnt <= n_cnt;
        end
    end

    // Rank lookup; the extra top bit reads as invalid past the list end
    assign valid_ext = {1'b0, r_valid};
    assign rank_nx   = r_rank + 1'b1;

    always_comb begin
        sel_id = '0;
        for (int i = 0; i < MAX_TOP; i++) begin
            if (r_rank == RNK_W'(i)) begin
                sel_id = r_ids[i];
            end
        end
    end

    // Drop the entry of the current id and close the gap
    always_comb begin
        logic hit_seen;
        hit_seen = 1'b0;
        for (int r = 0; r < MAX_TOP; r++) begin
            hit_seen = hit_seen || (r_valid[r] && (r_ids[r] == r_id));
            if (hit_seen && (r < MAX_TOP - 1)) begin
                rm_ids[r]   = r_ids[(r + 1) % MAX_TOP];
                rm_cnts[r]  = r_cnts[(r + 1) % MAX_TOP];
                rm_valid[r] = r_valid[(r + 1) % MAX_TOP];
            end else if (hit_seen) begin
                rm_ids[r]   = '0;
                rm_cnts[r]  = '0;
                rm_valid[r] = 1'b0;
            end else begin
                rm_ids[r]   = r_ids[r];
                rm_cnts[r]  = r_cnts[r];
                rm_valid[r] = r_valid[r];
            end
        end
    end

    // Insert the current id ahead of the first entry it outranks
    always_comb begin
        logic passed;
        logic passed_prev;
        logic ahead;
        passed      = 1'b0;
        passed_prev = 1'b0;
        ahead       = 1'b0;
        for (int r = 0; r < MAX_TOP; r++) begin
            ahead = !r_valid[r] || (r_cnt > r_cnts[r]) ||
                    ((r_cnt == r_cnts[r]) && (r_id < r_ids[r]));
            passed_prev = passed;
            passed      = passed || ahead;
            if (!passed) begin
                in_ids[r]   = r_ids[r];
                in_cnts[r]  = r_cnts[r];
                in_valid[r] = r_valid[r];
            end else if (!passed_prev) begin
                in_ids[r]   = r_id;
                in_cnts[r]  = r_cnt;
                in_valid[r] = 1'b1;
            end else begin
                in_ids[r]   = r_ids[(r + MAX_TOP - 1) % MAX_TOP];
                in_cnts[r]  = r_cnts[(r + MAX_TOP - 1) % MAX_TOP];
                in_valid[r] = r_valid[(r + MAX_TOP - 1) % MAX_TOP];
            end
        end
    end

    // List valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.update) begin
            r_valid <= rm_valid;
        end else if (i_cmd.insert) begin
            r_valid <= in_valid;
        end
    end

    // List payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ids  <= rm_ids;
            r_cnts <= rm_cnts;
        end else if (i_cmd.insert) begin
            r_ids  <= in_ids;
            r_cnts <= in_cnts;
        end
    end

    // Pack one result beat
    always_comb begin
        n_out_data = '0;
        n_out_data[ID_W-1:0]                  = r_id;
        n_out_data[2*ID_W-1:ID_W]             = sel_id;
        n_out_data[2*ID_W+RANK_W-1:2*ID_W]    = RANK_W'(r_rank);
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= n_out_data;
            r_out_last <= o_sts.emit_last;
        end
    end

    // Status
    assign o_sts.clr_done  = (r_clr_addr == ID_W'(ID_SPACE - 1));
    assign o_sts.emit_more = (r_rank < r_k) && valid_ext[r_rank];
    assign o_sts.emit_last = (rank_nx == r_k) || !valid_ext[rank_nx];
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== design/top_k_frequency_ranker_core.sv =====
// Top level of the top-K frequency ranker: stream ports, APB register, controller and datapath.
`timescale 1ns / 1ps

// For every item id taken on the input stream the block first sends the current
// top list, one beat per rank from rank 0, up to top_count entries (clamped to
// 1..10; fewer while fewer ids have been seen, none before the first item), with
// tlast on the final beat; it then bumps that id's count (saturating at 65535)
// and re-ranks. Ties rank the smaller id first. For each item the controller
// takes the item and reads its count from the count memory, loads each beat into
// the output register (only a check when there is none), then writes the count
// and drops the id's old entry, and re-inserts it in the ten-entry list; a
// stalled output holds it in the emit step. After reset the block clears all
// 1024 count memory entries, during which it takes no items; the top_count
// register can be written meanwhile.

module top_k_frequency_ranker_core import tkfr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] item_id, zero padding above
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [9:0] query_id, [19:10] ranked_id,
                                                   // [23:20] rank
    output logic                   m_axis_tlast,   // last
    // Configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [TOPK_W-1:0] r_top_count;
    t_cmd              cmd;
    t_sts              sts;

    // Top count register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= TOP_COUNT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == CFG_ADDR_TOP_COUNT)) begin
            r_top_count <= pwdata[TOPK_W-1:0];
        end
    end

    // Register read
    always_comb begin
        prdata = '0;
        unique case (paddr)
            CFG_ADDR_TOP_COUNT: prdata[TOPK_W-1:0] = r_top_count;
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    tkfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    tkfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item_id   (s_axis_tdata[ID_W-1:0]),
        .i_top_count (r_top_count),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

// ===== design/tkfr_checker.sv =====
// Port-level checks of the top-K frequency ranker, bound to the top level.
`timescale 1ns / 1ps

module tkfr_checker import tkfr_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // Reported rank stays inside the list
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[2*ID_W+RANK_W-1:2*ID_W]) < MAX_TOP))
        else $error("rank beyond list depth");

    // No new item is taken in the cycle after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A run in progress blocks the input
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("input taken in the middle of a run");

endmodule

bind top_k_frequency_ranker_core tkfr_checker u_tkfr_checker (.*);
